// File: rtl/smbs_pkg.sv
// Shared types, register indexes and helpers for the sorted matrix search block.
package smbs_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;
   localparam int INDEX_W = 6;

   // Register indexes on the configuration port
   localparam logic CSR_ROWS_IN_USE = 1'b0;
   localparam logic CSR_COLS_IN_USE = 1'b1;

   localparam logic [COUNT_W-1:0] ROWS_RESET = 7'd64;
   localparam logic [COUNT_W-1:0] COLS_RESET = 7'd64;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Status handed from the search engine to the top level
   typedef struct packed {
      logic done;
      logic found;
   } search_status_type;

   // Saturate a register count into 1..limit
   function automatic int clamp_count(input logic [COUNT_W-1:0] v, input int limit);
      int r;
      r = int'(v);
      if (r == 0) begin
         r = 1;
      end else if (r > limit) begin
         r = limit;
      end
      return r;
   endfunction

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// File: rtl/sorted_matrix_binary_search.sv
// Top level of the sorted matrix search block: ports, registers, write path, result buffer.
//
// Usage:
//   req channel: one request per handshake. tuser carries the mode: a write stores
//   tdata's value at (row_index, col_index) and gives no response; a query searches
//   for the value and gives exactly one rsp response, found in rsp_tdata bit 0.
//   csr port: rows_in_use (index 0) and cols_in_use (index 1), written while idle.
//   Counts saturate into 1..MAX_ROWS and 1..MAX_COLS when used.
// Requests and queries:
//   A write does not stall the channel; req_tready stays high for the next request.
//   A query runs a row search of up to ceil(log2(rows+1)) probes (two memory reads,
//   then a compare), then a column search of up to ceil(log2(cols+1)) probes (one
//   read, then a compare), all through the single read port of the matrix memory.
//   req_tready is low while a query runs.
// Reset:
//   Clears the control state and the registers to 64 rows and 64 columns. The
//   matrix memory is not cleared; only written elements may be searched.
// Stall:
//   A response waits in the output register while rsp_tready is low; requests keep being taken,
//   but a further finished query waits aside until the register frees, and req_tready stays low meanwhile.
module sorted_matrix_binary_search #(
   parameter int MAX_ROWS = smbs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = smbs_pkg::DEF_MAX_COLS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [47:0]                   req_tdata,  // row_index[5:0], col_index[11:6],
                                                     // value[43:12], zero pad
   input  logic                          req_tuser,  // mode
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // found[0], zero pad
   // configuration port
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [smbs_pkg::COUNT_W-1:0]  csr_wdata
);

   localparam int RW = $clog2(MAX_ROWS+1);
   localparam int CW = $clog2(MAX_COLS+1);
   localparam int AW = smbs_pkg::addr_width(MAX_ROWS*MAX_COLS);

   logic [smbs_pkg::COUNT_W-1:0] rows_ff, rows_in;
   logic [smbs_pkg::COUNT_W-1:0] cols_ff, cols_in;
   logic                         busy_ff, busy_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic                         pend_found_ff, pend_found_in;

   logic [smbs_pkg::INDEX_W-1:0] req_row;
   logic [smbs_pkg::INDEX_W-1:0] req_col;
   logic [smbs_pkg::DATA_W-1:0]  req_value;
   logic                         req_fire;
   logic                         query_start;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [AW-1:0]                rd_addr;
   logic [smbs_pkg::DATA_W-1:0]  rd_data;
   logic [RW-1:0]                rows_used;
   logic [CW-1:0]                cols_used;
   logic                         out_free;
   smbs_pkg::search_status_type  status;

   // unpack the request
   assign req_row   = req_tdata[5:0];
   assign req_col   = req_tdata[11:6];
   assign req_value = req_tdata[43:12];

   assign req_tready  = !busy_ff;
   assign req_fire    = req_tvalid && req_tready;
   assign query_start = req_fire && (req_tuser == smbs_pkg::MODE_QUERY);

   // drop writes that fall outside the store
   assign wr_en = req_fire && (req_tuser == smbs_pkg::MODE_WRITE)
                  && (int'(req_row) < MAX_ROWS) && (int'(req_col) < MAX_COLS);
   assign wr_addr = AW'(req_row) * AW'(MAX_COLS) + AW'(req_col);

   assign rows_used = RW'(smbs_pkg::clamp_count(rows_ff, MAX_ROWS));
   assign cols_used = CW'(smbs_pkg::clamp_count(cols_ff, MAX_COLS));

   smbs_ram #(
      .WIDTH (smbs_pkg::DATA_W),
      .DEPTH (MAX_ROWS*MAX_COLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   smbs_search #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_search (
      .clock   (clock),
      .reset   (reset),
      .start   (query_start),
      .target  ($signed(req_value)),
      .rows    (rows_used),
      .cols    (cols_used),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .status  (status)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      pend_valid_in = pend_valid_ff;
      pend_found_in = pend_found_ff;

      if (csr_we) begin
         case (csr_addr)
            smbs_pkg::CSR_ROWS_IN_USE: rows_in = csr_wdata;
            smbs_pkg::CSR_COLS_IN_USE: cols_in = csr_wdata;
            default: ;
         endcase
      end

      if (query_start) begin
         busy_in = 1'b1;
      end

      // retire the response register when taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // load a finished query, or hold it aside until the register frees
      if (pend_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = pend_found_ff;
         pend_valid_in = 1'b0;
         busy_in       = 1'b0;
      end else if (status.done) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = status.found;
            busy_in      = 1'b0;
         end else begin
            pend_valid_in = 1'b1;
            pend_found_in = status.found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= smbs_pkg::ROWS_RESET;
         cols_ff       <= smbs_pkg::COLS_RESET;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      rsp_found_ff  <= rsp_found_in;
      pend_found_ff <= pend_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_found_ff};

endmodule

// File: rtl/smbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module smbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [smbs_pkg::addr_width(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [smbs_pkg::addr_width(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/smbs_search.sv
// Two-level binary search engine that probes the matrix memory one read at a time.
module smbs_search #(
   parameter int MAX_ROWS = smbs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = smbs_pkg::DEF_MAX_COLS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            start,
   input  logic signed [smbs_pkg::DATA_W-1:0]              target,
   input  logic [$clog2(MAX_ROWS+1)-1:0]                   rows,
   input  logic [$clog2(MAX_COLS+1)-1:0]                   cols,
   output logic [smbs_pkg::addr_width(MAX_ROWS*MAX_COLS)-1:0] rd_addr,
   input  logic [smbs_pkg::DATA_W-1:0]                     rd_data,
   output smbs_pkg::search_status_type                     status
);

   localparam int RW = $clog2(MAX_ROWS+1);
   localparam int CW = $clog2(MAX_COLS+1);
   localparam int SW = (RW > CW) ? RW : CW;
   localparam int AW = smbs_pkg::addr_width(MAX_ROWS*MAX_COLS);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ROW_A = 6'b000010,
      S_ROW_B = 6'b000100,
      S_ROW_C = 6'b001000,
      S_COL_A = 6'b010000,
      S_COL_B = 6'b100000
   } state_type;

   state_type                          state_ff, state_in;
   logic [SW-1:0]                      lo_ff, lo_in;
   logic [SW-1:0]                      end_ff, end_in;
   logic [SW-1:0]                      mid_ff, mid_in;
   logic [SW-1:0]                      mid_calc;
   logic [SW-1:0]                      row_ff, row_in;
   logic [CW-1:0]                      cols_ff, cols_in;
   logic signed [smbs_pkg::DATA_W-1:0] target_ff, target_in;
   logic signed [smbs_pkg::DATA_W-1:0] first_ff, first_in;
   logic signed [smbs_pkg::DATA_W-1:0] elem;
   logic                               done_ff, done_in;
   logic                               found_ff, found_in;

   assign elem     = $signed(rd_data);
   assign mid_calc = lo_ff + ((end_ff - lo_ff - SW'(1)) >> 1);

   // Memory address: row * MAX_COLS + column
   always_comb begin
      case (state_ff)
         S_ROW_A: rd_addr = AW'(mid_calc) * AW'(MAX_COLS);
         S_ROW_B: rd_addr = AW'(mid_ff) * AW'(MAX_COLS) + AW'(cols_ff - CW'(1));
         S_COL_A: rd_addr = AW'(row_ff) * AW'(MAX_COLS) + AW'(mid_calc);
         default: rd_addr = AW'(mid_ff) * AW'(MAX_COLS);
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      end_in    = end_ff;
      mid_in    = mid_ff;
      row_in    = row_ff;
      cols_in   = cols_ff;
      target_in = target_ff;
      first_in  = first_ff;
      done_in   = 1'b0;
      found_in  = found_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               target_in = target;
               cols_in   = cols;
               lo_in     = '0;
               end_in    = SW'(rows);
               state_in  = S_ROW_A;
            end
         end
         S_ROW_A: begin
            // probe the first element of the middle row
            if (lo_ff >= end_ff) begin
               found_in = 1'b0;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               mid_in   = mid_calc;
               state_in = S_ROW_B;
            end
         end
         S_ROW_B: begin
            first_in = elem;
            state_in = S_ROW_C;
         end
         S_ROW_C: begin
            if (first_ff <= target_ff && elem >= target_ff) begin
               row_in   = mid_ff;
               lo_in    = '0;
               end_in   = SW'(cols_ff);
               state_in = S_COL_A;
            end else if (first_ff > target_ff) begin
               end_in   = mid_ff;
               state_in = S_ROW_A;
            end else begin
               lo_in    = mid_ff + SW'(1);
               state_in = S_ROW_A;
            end
         end
         S_COL_A: begin
            if (lo_ff >= end_ff) begin
               found_in = 1'b0;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               mid_in   = mid_calc;
               state_in = S_COL_B;
            end
         end
         S_COL_B: begin
            if (elem == target_ff) begin
               found_in = 1'b1;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else if (elem < target_ff) begin
               lo_in    = mid_ff + SW'(1);
               state_in = S_COL_A;
            end else begin
               end_in   = mid_ff;
               state_in = S_COL_A;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      lo_ff     <= lo_in;
      end_ff    <= end_in;
      mid_ff    <= mid_in;
      row_ff    <= row_in;
      cols_ff   <= cols_in;
      target_ff <= target_in;
      first_ff  <= first_in;
      found_ff  <= found_in;
   end

   assign status.done  = done_ff;
   assign status.found = found_ff;

endmodule

// File: dv/sorted_matrix_binary_search_tb.sv
// Self-checking testbench for the sorted matrix search block: row/column binary search over stored data.
`timescale 1ns / 100ps

// Mirror of the matrix and both count registers, with a queue of pending search answers
class search_scoreboard;
   localparam int ROWS_MAX = smbs_pkg::DEF_MAX_ROWS;
   localparam int COLS_MAX = smbs_pkg::DEF_MAX_COLS;

   int cells [ROWS_MAX*COLS_MAX];
   logic [smbs_pkg::COUNT_W-1:0] rows_reg = smbs_pkg::ROWS_RESET;
   logic [smbs_pkg::COUNT_W-1:0] cols_reg = smbs_pkg::COLS_RESET;
   bit found_due [$];
   int errors = 0;

   function void set_register(input logic addr, input logic [smbs_pkg::COUNT_W-1:0] data);
      if (addr == smbs_pkg::CSR_ROWS_IN_USE) begin
         rows_reg = data;
      end else begin
         cols_reg = data;
      end
   endfunction

   // Counts saturate into 1..max when used; the register keeps the raw value
   function int rows_used();
      if (rows_reg == 0) return 1;
      if (rows_reg > ROWS_MAX) return ROWS_MAX;
      return int'(rows_reg);
   endfunction

   function int cols_used();
      if (cols_reg == 0) return 1;
      if (cols_reg > COLS_MAX) return COLS_MAX;
      return int'(cols_reg);
   endfunction

   // Outer search over row ranges, inner search within the bracketing row
   function bit lookup(input int target);
      int lo, hi, mid, first, last, n_cols, c_lo, c_hi, c_mid, probe;
      n_cols = cols_used();
      lo = 0;
      hi = rows_used() - 1;
      while (lo <= hi) begin
         mid   = lo + (hi - lo) / 2;
         first = cells[mid*COLS_MAX];
         last  = cells[mid*COLS_MAX + n_cols - 1];
         if (first <= target && last >= target) begin
            c_lo = 0;
            c_hi = n_cols - 1;
            while (c_lo <= c_hi) begin
               c_mid = c_lo + (c_hi - c_lo) / 2;
               probe = cells[mid*COLS_MAX + c_mid];
               if (probe == target) return 1'b1;
               if (probe < target) c_lo = c_mid + 1;
               else c_hi = c_mid - 1;
            end
            return 1'b0;
         end
         if (first > target) hi = mid - 1;
         else lo = mid + 1;
      end
      return 1'b0;
   endfunction

   function void note_request(input logic mode, input logic [5:0] row, input logic [5:0] col,
                              input int value);
      if (mode == smbs_pkg::MODE_WRITE) begin
         cells[int'(row)*COLS_MAX + int'(col)] = value;
      end else begin
         found_due.push_back(lookup(value));
      end
   endfunction

   function void check_response(input logic got);
      bit want;
      if (found_due.size() == 0) begin
         $error("found: expected no response, actual %0b", got);
         errors++;
         return;
      end
      want = found_due.pop_front();
      if (got !== want) begin
         $error("found: expected %0b, actual %0b", want, got);
         errors++;
      end
   endfunction

   function int pending();
      return found_due.size();
   endfunction
endclass

module sorted_matrix_binary_search_tb;

   localparam int ITEM_TARGET   = 1300;
   localparam int QUIET_ITEMS   = 150;    // final stretch run without any idling
   localparam int SETTLE_CYCLES = 50;     // margin to let the last query finish
   localparam int HOLD_CYCLES   = 300;    // long receiver hold-off for back-pressure
   localparam int STALL_LIMIT   = 2000;   // cycles without any handshake before giving up
   localparam int OPS_PER_PHASE = 30;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [47:0]                   req_tdata = '0;   // row_index[5:0], col_index[11:6],
                                                    // value[43:12], pad
   logic                          req_tuser = 1'b0; // mode
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [7:0]                    rsp_tdata;        // found[0], pad
   logic                          csr_we = 1'b0;
   logic                          csr_addr = 1'b0;
   logic [smbs_pkg::COUNT_W-1:0]  csr_wdata = '0;

   search_scoreboard book = new();

   int items_sent    = 0;
   int quiet_cycles  = 0;
   bit quiet_tail    = 1'b0;   // set near the end: no gaps, no stalls
   bit gaps_on       = 1'b1;
   bit hold_requests = 1'b0;   // raised by the stimulus, served by the receiver

   sorted_matrix_binary_search u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Check responses and watch for a hang; both sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         book.check_response(rsp_tdata[0]);
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stall bursts, quiet stretches, and one long hold-off on request
   initial begin
      int cyc;
      bit stalls_on;
      bit held;
      cyc = 0;
      stalls_on = 1'b1;
      held = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 128 == 0) begin
            stalls_on = ($urandom_range(0, 2) != 0);
         end
         if (hold_requests && !held) begin
            // Hold off long enough for the result register to fill and the input to stall
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1'b1;
            rsp_tready = 1'b1;
         end else if (!reset && !quiet_tail && stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = !reset;
         end
      end
   end

   // Offer one request and wait for its handshake; returns after the following falling edge,
   // with tvalid still high or, after a random gap, low; the caller replaces the request or drops tvalid.
   task automatic push_request(input logic mode, input logic [5:0] row, input logic [5:0] col,
                               input int value);
      req_tuser  = mode;
      req_tdata  = {4'b0, value, col, row};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(mode, row, col, value);
      items_sent++;
      @(negedge clock);
      if (!quiet_tail && gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
   endtask

   task automatic write_csr(input logic addr, input logic [smbs_pkg::COUNT_W-1:0] data);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      book.set_register(addr, data);
   endtask

   // Drain every outstanding answer, then allow for a write still in flight
   task automatic settle();
      req_tvalid = 1'b0;
      while (book.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One phase: set the counts, fill the region in use with sorted data, then mix
   // queries (half aimed at stored values) with writes anywhere in the store.
   task automatic run_phase(input logic [smbs_pkg::COUNT_W-1:0] rows_cfg,
                            input logic [smbs_pkg::COUNT_W-1:0] cols_cfg, input bit squeeze);
      int n_rows, n_cols, step_max, r, c, target;
      longint span, next_val;
      settle();
      write_csr(smbs_pkg::CSR_ROWS_IN_USE, rows_cfg);
      write_csr(smbs_pkg::CSR_COLS_IN_USE, cols_cfg);
      n_rows  = book.rows_used();
      n_cols  = book.cols_used();
      gaps_on = ($urandom_range(0, 2) != 0);

      // Non-decreasing values over the whole region, row by row, so row ranges stay in order
      step_max = 1 << $urandom_range(0, 24);
      span     = longint'(n_rows * n_cols) * step_max;
      next_val = -64'sd2147483648 + (longint'({32'b0, $urandom()}) % (64'sd4294967296 - span));
      for (r = 0; r < n_rows; r++) begin
         for (c = 0; c < n_cols; c++) begin
            push_request(smbs_pkg::MODE_WRITE, r[5:0], c[5:0], int'(next_val));
            next_val += $urandom_range(0, step_max);
         end
      end

      if (squeeze) hold_requests = 1'b1;

      repeat (OPS_PER_PHASE) begin
         if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet_tail = 1'b1;
         r = $urandom_range(0, n_rows - 1);
         c = $urandom_range(0, n_cols - 1);
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: target = book.cells[r*smbs_pkg::DEF_MAX_COLS + c];
               5:             target = book.cells[r*smbs_pkg::DEF_MAX_COLS + c] + 1;
               6:             target = book.cells[r*smbs_pkg::DEF_MAX_COLS + c] - 1;
               7:             target = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
               default:       target = $urandom();
            endcase
            push_request(smbs_pkg::MODE_QUERY, 6'($urandom()), 6'($urandom()), target);
         end else if ($urandom_range(0, 7) == 0) begin
            // Break the order inside the region now and then
            push_request(smbs_pkg::MODE_WRITE, r[5:0], c[5:0], $urandom());
         end else begin
            push_request(smbs_pkg::MODE_WRITE, 6'($urandom_range(0, 63)),
                         6'($urandom_range(0, 63)), $urandom());
         end
      end
   endtask

   initial begin
      logic [smbs_pkg::COUNT_W-1:0] rows_cfg, cols_cfg;
      bit first_random;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: a 2 x 2 matrix spanning the whole signed range
      write_csr(smbs_pkg::CSR_ROWS_IN_USE, 7'd2);
      write_csr(smbs_pkg::CSR_COLS_IN_USE, 7'd2);
      push_request(smbs_pkg::MODE_WRITE, 6'd0, 6'd0, 32'h8000_0000);
      push_request(smbs_pkg::MODE_WRITE, 6'd0, 6'd1, -5);
      push_request(smbs_pkg::MODE_WRITE, 6'd1, 6'd0, 7);
      push_request(smbs_pkg::MODE_WRITE, 6'd1, 6'd1, 32'h7fff_ffff);
      // Writes outside the rows and columns in use: stored, never searched
      push_request(smbs_pkg::MODE_WRITE, 6'd63, 6'd63, 32'h5555_5555);
      push_request(smbs_pkg::MODE_WRITE, 6'd42, 6'd21, 32'haaaa_aaaa);
      push_request(smbs_pkg::MODE_WRITE, 6'd21, 6'd42, -1);
      push_request(smbs_pkg::MODE_WRITE, 6'd0, 6'd63, 0);
      push_request(smbs_pkg::MODE_QUERY, 6'd0, 6'd0, 32'h8000_0000);
      push_request(smbs_pkg::MODE_QUERY, 6'd63, 6'd63, 32'h7fff_ffff);
      push_request(smbs_pkg::MODE_QUERY, 6'd5, 6'd9, -5);
      push_request(smbs_pkg::MODE_QUERY, 6'd0, 6'd0, 7);
      push_request(smbs_pkg::MODE_QUERY, 6'd0, 6'd0, 0);     // gap between the two rows
      push_request(smbs_pkg::MODE_QUERY, 6'd0, 6'd0, -6);    // bracketed by row 0, absent
      push_request(smbs_pkg::MODE_QUERY, 6'd0, 6'd0, 8);     // bracketed by row 1, absent
      push_request(smbs_pkg::MODE_QUERY, 6'd0, 6'd0, 6);
      // Unsorted data: the search still runs to a response
      push_request(smbs_pkg::MODE_WRITE, 6'd1, 6'd0, 32'h7fff_ffff);
      push_request(smbs_pkg::MODE_QUERY, 6'd0, 6'd0, 7);
      push_request(smbs_pkg::MODE_QUERY, 6'd0, 6'd0, 32'h7fff_ffff);

      // Register extremes, including the saturating values
      run_phase(7'd0,   7'd127, 1'b0);
      run_phase(7'd127, 7'd0,   1'b0);
      run_phase(7'd64,  7'd1,   1'b0);
      run_phase(7'd1,   7'd64,  1'b0);
      run_phase(7'd1,   7'd1,   1'b0);

      // Random phases, mostly small, with the long hold-off in the first one
      first_random = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: begin
               rows_cfg = 7'($urandom_range(64, 127));
               cols_cfg = 7'($urandom_range(1, 2));
            end
            1: begin
               rows_cfg = 7'($urandom_range(1, 2));
               cols_cfg = 7'($urandom_range(64, 127));
            end
            default: begin
               rows_cfg = 7'($urandom_range(1, 8));
               cols_cfg = 7'($urandom_range(1, 8));
            end
         endcase
         run_phase(rows_cfg, cols_cfg, first_random);
         first_random = 1'b0;
      end

      settle();
      if (book.errors == 0 && book.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
